### design/afc_pkg.sv
// ---------------------------------------------------------------------------
// afc_pkg
// shared types and constants for the api frame checker
// ---------------------------------------------------------------------------
`default_nettype none

package afc_pkg;

    localparam int unsigned IDX_W    = 17;
    localparam int unsigned LEN_W    = 16;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned PADDR_W  = 3;
    localparam int unsigned PDATA_W  = 32;

    localparam logic [IDX_W-1:0]   IDX_MAX          = '1;
    localparam logic [BYTE_W-1:0]  START_DELIM_RST  = 8'h7E;
    localparam logic [BYTE_W-1:0]  SUM_GOOD         = 8'hFF;

    // register byte addresses
    localparam logic [PADDR_W-1:0] ADDR_START_DELIM = 3'd0;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_DELIM = 2'd1,
        ST_BAD_LEN   = 2'd2,
        ST_BAD_SUM   = 2'd3
    } t_status;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
    } t_in_item;

    typedef struct packed {
        t_status           status;
        logic [LEN_W-1:0]  length_field;
        logic [BYTE_W-1:0] api_id;
        logic [BYTE_W-1:0] received_checksum;
    } t_out_item;

endpackage

`default_nettype wire

### design/api_frame_checker_core.sv
// ---------------------------------------------------------------------------
// api_frame_checker_core
// byte-serial check of delimited, length-prefixed, checksummed frames
// ---------------------------------------------------------------------------
// Takes one frame byte per cycle and gives one verdict per frame, on the
// byte that carries the last flag. A byte sits in the input register, where
// a short update of the frame state (delimiter match, length bytes, api id,
// running sum) and the verdict logic run; the verdict lands in the output
// register when the last byte leaves the input register. Sustained rate is
// one byte per clock; the input register stalls only while it holds a last
// byte and the output register holds an untaken verdict.
// The start delimiter register sits at byte address 0 of the register port.
`default_nettype none

module api_frame_checker_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // byte input
    input  wire logic                          i_in_valid,
    input  wire afc_pkg::t_in_item             i_in_data,
    output logic                               o_in_stall,
    // verdict output
    output logic                               o_out_valid,
    output afc_pkg::t_out_item                 o_out_data,
    input  wire logic                          i_out_stall,
    // register port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [afc_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [afc_pkg::PDATA_W-1:0]   pwdata,
    output logic      [afc_pkg::PDATA_W-1:0]   prdata,
    output logic                               pready
);
    import afc_pkg::*;

    logic [BYTE_W-1:0] r_start_delim;

    logic              r_in_valid;
    t_in_item          r_in;

    logic              r_out_valid;
    t_out_item         r_out;

    logic [IDX_W-1:0]  r_byte_index;
    logic              r_delim_ok;
    logic [LEN_W-1:0]  r_length;
    logic [BYTE_W-1:0] r_sum;
    logic [BYTE_W-1:0] r_api;

    logic [IDX_W-1:0]  n_byte_index;
    logic              n_delim_ok;
    logic [LEN_W-1:0]  n_length;
    logic [BYTE_W-1:0] n_sum;
    logic [BYTE_W-1:0] n_api;
    t_out_item         n_out;

    logic              out_free;
    logic              advance;
    logic              cfg_write;
    logic [IDX_W-1:0]  idx_m3;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        prdata = '0;
        if (paddr == ADDR_START_DELIM) begin
            prdata = {{(PDATA_W-BYTE_W){1'b0}}, r_start_delim};
        end
    end

    // a non-last byte needs no room downstream
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && (!r_in.last_byte || out_free);
    assign o_in_stall = r_in_valid && !advance;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign idx_m3 = r_byte_index - IDX_W'(3);

    always_comb begin
        n_delim_ok = r_delim_ok;
        n_length   = r_length;
        n_api      = r_api;
        n_sum      = r_sum;
        if (r_byte_index == IDX_W'(0)) begin
            n_delim_ok = (r_in.data_byte == r_start_delim);
        end
        if (r_byte_index == IDX_W'(1)) begin
            n_length = {r_in.data_byte, {BYTE_W{1'b0}}};
        end
        if (r_byte_index == IDX_W'(2)) begin
            n_length = {r_length[LEN_W-1:BYTE_W], r_in.data_byte};
        end
        if (r_byte_index == IDX_W'(3)) begin
            n_api = r_in.data_byte;
        end
        if (r_byte_index >= IDX_W'(3)) begin
            n_sum = r_sum + r_in.data_byte;
        end

        if (r_byte_index == IDX_MAX) begin
            n_byte_index = r_byte_index;
        end else begin
            n_byte_index = r_byte_index + IDX_W'(1);
        end

        n_out.length_field      = (r_byte_index >= IDX_W'(2)) ? n_length : '0;
        n_out.api_id            = (r_byte_index >= IDX_W'(3)) ? n_api : '0;
        n_out.received_checksum = r_in.data_byte;
        // count - 4 == length  <=>  index - 3 == length
        priority if (!n_delim_ok) begin
            n_out.status = ST_BAD_DELIM;
        end else if (r_byte_index < IDX_W'(3) || idx_m3 != {1'b0, n_length}) begin
            n_out.status = ST_BAD_LEN;
        end else if (n_sum != SUM_GOOD) begin
            n_out.status = ST_BAD_SUM;
        end else begin
            n_out.status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_delim <= START_DELIM_RST;
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_byte_index  <= '0;
            r_delim_ok    <= 1'b0;
            r_length      <= '0;
            r_sum         <= '0;
            r_api         <= '0;
        end else begin
            if (cfg_write && paddr == ADDR_START_DELIM) begin
                r_start_delim <= pwdata[BYTE_W-1:0];
            end

            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end

            if (out_free) begin
                r_out_valid <= advance && r_in.last_byte;
            end

            if (advance) begin
                if (r_in.last_byte) begin
                    r_byte_index <= '0;
                    r_delim_ok   <= 1'b0;
                    r_length     <= '0;
                    r_sum        <= '0;
                    r_api        <= '0;
                end else begin
                    r_byte_index <= n_byte_index;
                    r_delim_ok   <= n_delim_ok;
                    r_length     <= n_length;
                    r_sum        <= n_sum;
                    r_api        <= n_api;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in <= i_in_data;
        end
        if (advance && r_in.last_byte) begin
            r_out <= n_out;
        end
    end

`ifndef SYNTHESIS
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in.last_byte) |=> (r_byte_index == '0 && !r_delim_ok && r_sum == '0))
        else $error("frame state not cleared after last byte");

    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && !r_in.last_byte && r_byte_index != IDX_MAX)
        |=> (r_byte_index == $past(r_byte_index) + IDX_W'(1)))
        else $error("byte index did not advance");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_in.last_byte && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked verdict");

    a_verdict_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !$past(o_out_valid)) |-> $past(advance && r_in.last_byte))
        else $error("verdict without a last byte");
`endif

endmodule

`default_nettype wire

### dv/api_frame_checker_core_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// api_frame_checker_core_tb
// self-checking bench for the byte-serial api frame checker
// ---------------------------------------------------------------------------
// Drives frame bytes through the valid/stall input and keeps its own model of
// the frame state, so each last byte queues the verdict it should produce.
// The output side compares every verdict field against that queue. Directed
// frames hit short, four-byte and delimiter cases. A dedicated long frame
// uses both length bytes. The start delimiter register is moved between
// phases, and twice in the middle of a frame. The bulk is random frames,
// mostly well formed, with random gaps and stalls outside the middle phase.
// ---------------------------------------------------------------------------

module api_frame_checker_core_tb;
    import afc_pkg::*;

    typedef logic [7:0] t_byte_q[$];

    localparam int unsigned CLK_LIMIT    = 1_500_000;
    localparam int unsigned DRAIN_CYCLES = 6;
    localparam int unsigned RAND_BYTES   = 180;  // per random phase

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    t_in_item             i_in_data;
    logic                 o_in_stall;
    logic                 o_out_valid;
    t_out_item            o_out_data;
    logic                 i_out_stall;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    // model of the frame state
    logic [7:0]           delim_reg;
    logic [IDX_W-1:0]     pos_cnt;
    logic                 delim_match;
    logic [LEN_W-1:0]     len_hold;
    logic [7:0]           sum_acc;
    logic [7:0]           api_hold;

    t_out_item            pending_verdicts[$];
    t_out_item            head_verdict;
    int unsigned          err_count;
    int unsigned          verdict_count;
    int unsigned          bytes_sent;
    int unsigned          delim_writes;
    int unsigned          cycle_cnt;
    logic                 gaps_on;
    logic                 stalls_on;

    api_frame_checker_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CLK_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_out_stall <= stalls_on && ($urandom_range(99) < 34);
    end

    function automatic void log_error(input string msg);
        err_count++;
        if (err_count <= 10) begin
            $display("ERROR: %s", msg);
        end
    endfunction

    function automatic string verdict_str(input t_out_item v);
        return $sformatf("status=%0d len=%04h api=%02h csum=%02h",
                         v.status, v.length_field, v.api_id, v.received_checksum);
    endfunction

    function automatic void clear_frame_state();
        pos_cnt     = '0;
        delim_match = 1'b0;
        len_hold    = '0;
        sum_acc     = '0;
        api_hold    = '0;
    endfunction

    // absorb one accepted byte; a last byte queues the verdict
    function automatic void predict_verdict(input t_in_item req);
        logic [IDX_W:0] count;
        t_out_item      v;
        if (pos_cnt == 0) begin
            delim_match = (req.data_byte == delim_reg);
        end else if (pos_cnt == 1) begin
            len_hold = {req.data_byte, 8'h00};
        end else if (pos_cnt == 2) begin
            len_hold[7:0] = req.data_byte;
        end
        if (pos_cnt == 3) begin
            api_hold = req.data_byte;
        end
        if (pos_cnt >= 3) begin
            sum_acc = sum_acc + req.data_byte;
        end
        if (!req.last_byte) begin
            if (pos_cnt != IDX_MAX) begin
                pos_cnt = pos_cnt + 1'b1;
            end
        end else begin
            count               = {1'b0, pos_cnt} + 1'b1;
            v.length_field      = (count >= 3) ? len_hold : '0;
            v.api_id            = (count >= 4) ? api_hold : '0;
            v.received_checksum = req.data_byte;
            if (!delim_match) begin
                v.status = ST_BAD_DELIM;
            end else if (count < 4 || (count - 4) != {2'b00, len_hold}) begin
                v.status = ST_BAD_LEN;
            end else if (sum_acc != SUM_GOOD) begin
                v.status = ST_BAD_SUM;
            end else begin
                v.status = ST_OK;
            end
            pending_verdicts = {pending_verdicts, v};
            clear_frame_state();
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_verdicts.size() == 0) begin
                log_error($sformatf("unexpected verdict %s", verdict_str(o_out_data)));
            end else begin
                head_verdict = pending_verdicts.pop_front();
                verdict_count++;
                if (o_out_data.status !== head_verdict.status ||
                    o_out_data.length_field !== head_verdict.length_field ||
                    o_out_data.api_id !== head_verdict.api_id ||
                    o_out_data.received_checksum !== head_verdict.received_checksum) begin
                    log_error($sformatf("verdict mismatch: expected %s, got %s",
                                        verdict_str(head_verdict), verdict_str(o_out_data)));
                end
            end
        end
    end

    // called at a falling edge; returns at a falling edge with valid still up
    task automatic send_byte(input logic [7:0] b, input logic last);
        t_in_item req;
        req.data_byte = b;
        req.last_byte = last;
        while (gaps_on && ($urandom_range(99) < 34)) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (o_in_stall);
        predict_verdict(req);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_frame(input t_byte_q f, input int unsigned first = 0);
        for (int unsigned i = first; i < f.size(); i++) begin
            send_byte(f[i], i == f.size() - 1);
        end
    endtask

    // well-formed frame with body_len bytes between the length and checksum
    function automatic t_byte_q good_frame(input int unsigned body_len);
        t_byte_q    f;
        logic [7:0] b;
        logic [7:0] s;
        s = 8'h00;
        f = {f, delim_reg};
        f = {f, body_len[15:8]};
        f = {f, body_len[7:0]};
        for (int unsigned i = 0; i < body_len; i++) begin
            b = $urandom_range(255);
            f = {f, b};
            s = s + b;
        end
        f = {f, 8'(SUM_GOOD - s)};
        return f;
    endfunction

    // hold the input and wait for every queued verdict, then the pipeline
    task automatic drain_verdicts();
        i_in_valid <= 1'b0;
        while (pending_verdicts.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] a, input logic [PDATA_W-1:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= d;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic apb_read_check(input logic [PADDR_W-1:0] a, input logic [PDATA_W-1:0] exp_val);
        logic [PDATA_W-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= a;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        if (got !== exp_val) begin
            log_error($sformatf("register read at %0d: expected %08h, got %08h",
                                a, exp_val, got));
        end
    endtask

    task automatic set_delimiter(input logic [7:0] d);
        drain_verdicts();
        apb_write(ADDR_START_DELIM, {24'h0, d});
        delim_reg = d;
        delim_writes++;
        apb_read_check(ADDR_START_DELIM, {24'h0, d});
    endtask

    task automatic test_reset_value();
        apb_read_check(ADDR_START_DELIM, {24'h0, START_DELIM_RST});
    endtask

    task automatic test_directed_frames();
        t_byte_q f;
        // smallest passing frame: api id and checksum are one byte
        f = {START_DELIM_RST, 8'h00, 8'h00, 8'hFF};
        send_frame(f);
        f = {START_DELIM_RST, 8'h00, 8'h00, 8'h00};
        send_frame(f);
        // one-byte frame
        f = {START_DELIM_RST};
        send_frame(f);
        // wrong delimiter wins over short length
        f = {8'h00, 8'hFF};
        send_frame(f);
        f = {START_DELIM_RST, 8'h12, 8'h34};
        send_frame(f);
        f = {START_DELIM_RST, 8'h00, 8'h01, 8'hAA, 8'h55};
        send_frame(f);
        // right checksum, wrong length
        f = {START_DELIM_RST, 8'hFF, 8'hFF, 8'h0F, 8'hF0};
        send_frame(f);
    endtask

    task automatic test_delimiter_changes();
        t_byte_q    f;
        logic [7:0] d;
        set_delimiter(8'h00);
        send_frame(good_frame(2));
        f = good_frame(1);
        f[0] = START_DELIM_RST;
        send_frame(f);
        set_delimiter(8'hFF);
        send_frame(good_frame(0));
        send_frame(good_frame(3));
        d = $urandom_range(255);
        set_delimiter(d);
        send_frame(good_frame(4));
        // write between byte 0 and the rest: byte 0 was judged already
        f = good_frame(3);
        send_byte(f[0], 1'b0);
        set_delimiter(~d);
        send_frame(f, 1);
        f = good_frame(2);
        f[0] = d;
        send_byte(f[0], 1'b0);
        set_delimiter(d);
        send_frame(f, 1);
    endtask

    task automatic test_longest_frames();
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        set_delimiter(START_DELIM_RST);
        // length above 255 needs both length bytes
        send_frame(good_frame(260));
        drain_verdicts();
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
    endtask

    task automatic test_random_frames();
        t_byte_q     f;
        int unsigned start;
        int unsigned kind;
        int unsigned n;
        int unsigned k;
        logic [15:0] len_new;
        start = bytes_sent;
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    set_delimiter($urandom_range(255));
                end
                1: begin
                    set_delimiter(8'hFF);
                end
                default: begin
                    set_delimiter(START_DELIM_RST);
                end
            endcase
            // middle phase runs with no gaps and no stalls
            gaps_on   = (phase != 1);
            stalls_on = (phase != 1);
            while (bytes_sent - start < (phase + 1) * RAND_BYTES) begin
                n    = ($urandom_range(99) < 3) ? $urandom_range(200) : $urandom_range(12);
                f    = good_frame(n);
                kind = $urandom_range(99);
                if (kind < 10) begin
                    f[0] = f[0] ^ 8'($urandom_range(255, 1));
                end else if (kind < 20) begin
                    len_new = $urandom_range(65535);
                    if (len_new == n[15:0]) begin
                        len_new = len_new ^ 16'h0001;
                    end
                    f[1] = len_new[15:8];
                    f[2] = len_new[7:0];
                end else if (kind < 30) begin
                    k    = $urandom_range(f.size() - 1, 3);
                    f[k] = f[k] ^ 8'($urandom_range(255, 1));
                end else if (kind < 36) begin
                    f.delete();
                    n = $urandom_range(3, 1);
                    repeat (n) f = {f, 8'($urandom_range(255))};
                    if ($urandom_range(1) == 1) begin
                        f[0] = delim_reg;
                    end
                end else if (kind < 42) begin
                    f.delete();
                    n = $urandom_range(20, 1);
                    repeat (n) f = {f, 8'($urandom_range(255))};
                end
                send_frame(f);
                if ($urandom_range(99) < 3) begin
                    drain_verdicts();
                end
            end
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_stall = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        gaps_on     = 1'b1;
        stalls_on   = 1'b1;
        err_count     = 0;
        verdict_count = 0;
        bytes_sent    = 0;
        delim_writes  = 0;
        cycle_cnt     = 0;
        delim_reg     = START_DELIM_RST;
        clear_frame_state();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_value();
        test_directed_frames();
        test_delimiter_changes();
        test_longest_frames();
        test_random_frames();

        drain_verdicts();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (pending_verdicts.size() != 0) begin
            log_error($sformatf("%0d verdicts never arrived", pending_verdicts.size()));
        end
        $display("checked %0d verdicts from %0d bytes, %0d start delimiter writes",
                 verdict_count, bytes_sent, delim_writes);
        $display("included short, four-byte, long, corrupted and mid-frame write cases");
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("%0d errors", err_count);
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### sim.f
design/afc_pkg.sv
design/api_frame_checker_core.sv
dv/api_frame_checker_core_tb.sv
